### rtl/percent_decoder_filtered_macros.svh
// assertion macros shared by the checker of the percent decoder
// no dependencies
`ifndef PERCENT_DECODER_FILTERED_MACROS_SVH
`define PERCENT_DECODER_FILTERED_MACROS_SVH

// property checked while out of reset
`define PCTD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define PCTD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/pctd_pkg.sv
// types, constants and character helpers for the percent decoder
// no dependencies
package pctd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_PCT   = 2'd1,
        HELD_DIGIT = 2'd2
    } pctd_held_t;

    // up to three result bytes produced by one item
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      count;
        logic            string_end;
    } pctd_result_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'd48:8'd57], [8'd97:8'd102], [8'd65:8'd70]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c inside {[8'd48:8'd57]})
        begin
            v = c - 8'd48;
        end
        else if (c inside {[8'd97:8'd102]})
        begin
            v = c - 8'd87;
        end
        else if (c inside {[8'd65:8'd70]})
        begin
            v = c - 8'd55;
        end
        return v[3:0];
    endfunction

    function automatic logic in_keep_set(input logic [7:0] v, input logic component_mode);
        logic alnum;
        logic reserved;
        alnum    = (v inside {[8'd48:8'd57], [8'd97:8'd122], [8'd65:8'd90]});
        reserved = (v inside {8'h21, 8'h24, [8'h26:8'h2f], 8'h3A, 8'h3B, 8'h3D,
                              8'h3f, 8'h40, 8'h5f});
        return alnum || (!component_mode && reserved);
    endfunction

endpackage

### rtl/pctd_decode.sv
// escape decoding for one item: result bytes and the next held state
// depends on pctd_pkg
module pctd_decode
    import pctd_pkg::*;
(
    input  logic [7:0]   in_byte,
    input  logic         string_last,
    input  logic         component_mode,
    input  pctd_held_t   held_stage,
    input  logic [7:0]   held_digit,
    output pctd_held_t   held_stage_next,
    output logic [7:0]   held_digit_next,
    output pctd_result_t result
);

    logic [7:0] em [3];
    logic [1:0] n;
    logic       idle;
    logic [7:0] v;

    always_comb
    begin
        em              = '{default: 8'h00};
        n               = 2'd0;
        idle            = 1'b0;
        held_stage_next = HELD_NONE;
        held_digit_next = held_digit;
        v               = {hex_val(held_digit), hex_val(in_byte)};

        case (held_stage)
            HELD_PCT:
            begin
                if (is_hex(in_byte))
                begin
                    held_digit_next = in_byte;
                    held_stage_next = HELD_DIGIT;
                end
                else
                begin
                    em[0] = PCT_CHAR;
                    n     = 2'd1;
                    idle  = 1'b1;
                end
            end
            HELD_DIGIT:
            begin
                if (is_hex(in_byte))
                begin
                    if (in_keep_set(v, component_mode))
                    begin
                        em[0] = PCT_CHAR;
                        em[1] = held_digit;
                        em[2] = in_byte;
                        n     = 2'd3;
                    end
                    else
                    begin
                        em[0] = v;
                        n     = 2'd1;
                    end
                end
                else
                begin
                    em[0] = PCT_CHAR;
                    em[1] = held_digit;
                    n     = 2'd2;
                    idle  = 1'b1;
                end
            end
            default:
            begin
                idle = 1'b1;
            end
        endcase

        // byte handled as if nothing were held
        if (idle)
        begin
            if (in_byte == PCT_CHAR)
            begin
                held_stage_next = HELD_PCT;
            end
            else
            begin
                em[n] = in_byte;
                n     = n + 2'd1;
            end
        end

        // flush whatever is still held at the end of the string
        if (string_last)
        begin
            case (held_stage_next)
                HELD_PCT:
                begin
                    em[n] = PCT_CHAR;
                    n     = n + 2'd1;
                end
                HELD_DIGIT:
                begin
                    em[n]         = PCT_CHAR;
                    em[n + 2'd1]  = held_digit_next;
                    n             = n + 2'd2;
                end
                default:
                begin
                end
            endcase
            held_stage_next = HELD_NONE;
        end

        result.data       = {em[2], em[1], em[0]};
        result.count      = n;
        result.string_end = string_last;
    end

endmodule

### rtl/pctd_outbuf.sv
// result buffer: holds the bytes of one item and hands them out one per cycle while out_ready is high
// depends on pctd_pkg
module pctd_outbuf
    import pctd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  pctd_result_t result,
    output logic         load_ok,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_byte,
    output logic         run_last,
    output logic         string_end
);

    logic [2:0][7:0] data_reg;
    logic [1:0]      cnt_reg;
    logic [1:0]      idx_reg;
    logic            end_reg;
    logic            final_one;

    assign out_valid  = (idx_reg != cnt_reg);
    assign final_one  = ((idx_reg + 2'd1) == cnt_reg);
    assign load_ok    = !out_valid || (out_ready && final_one);
    assign out_byte   = data_reg[idx_reg];
    assign run_last   = final_one;
    assign string_end = final_one && end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
            end_reg <= 1'b0;
        end
        else if (load)
        begin
            cnt_reg <= result.count;
            idx_reg <= 2'd0;
            end_reg <= result.string_end;
        end
        else if (out_valid && out_ready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result.data;
        end
    end

endmodule

### rtl/percent_decoder_filtered.sv
// top level of the streaming percent decoder with keep set
// depends on pctd_pkg, pctd_decode and pctd_outbuf
//
// Decodes %XX escapes in a byte stream, passing escapes of kept characters
// and broken escapes through as text. An item enters an input register, is
// decoded in one pass against the held escape state, and its 0 to 3 result
// bytes land in a result buffer. While out_ready is high, the buffer hands
// out one byte per cycle and a new item is taken every cycle if items give
// at most one byte each; an item that gives more holds the input until its
// last byte is taken. An item passes the input register, then the result
// buffer, before its first byte is offered. component_mode may be written
// at any time the stream is idle and takes effect on the next item.
module percent_decoder_filtered
    import pctd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       component_mode,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       string_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_end
);

    logic         mode_reg;
    logic         inv_reg;
    logic [7:0]   byte_reg;
    logic         last_reg;
    pctd_held_t   held_stage_reg;
    pctd_held_t   held_stage_next;
    logic [7:0]   held_digit_reg;
    logic [7:0]   held_digit_next;
    pctd_result_t result;
    logic         load_ok;
    logic         advance;

    assign cfg_ready = 1'b1;
    assign advance   = inv_reg && load_ok;
    assign in_ready  = !inv_reg || load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            mode_reg <= component_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg        <= 1'b0;
            held_stage_reg <= HELD_NONE;
            held_digit_reg <= 8'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                inv_reg <= 1'b1;
            end
            else if (advance)
            begin
                inv_reg <= 1'b0;
            end
            if (advance)
            begin
                held_stage_reg <= held_stage_next;
                held_digit_reg <= held_digit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            last_reg <= string_last;
        end
    end

    pctd_decode u_decode (
        .in_byte         (byte_reg),
        .string_last     (last_reg),
        .component_mode  (mode_reg),
        .held_stage      (held_stage_reg),
        .held_digit      (held_digit_reg),
        .held_stage_next (held_stage_next),
        .held_digit_next (held_digit_next),
        .result          (result)
    );

    pctd_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result     (result),
        .load_ok    (load_ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule

### rtl/pctd_checker.sv
// port-level checks for the percent decoder, bound to the top level
// depends on percent_decoder_filtered_macros.svh
`include "percent_decoder_filtered_macros.svh"

module pctd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       string_end
);

    // end of string only on the last byte of an item's run
    `PCTD_ASSERT(a_end_on_run_last, clk, rst_n, out_valid && string_end |-> run_last, "string_end without run_last")

    // nothing is offered once reset has been applied
    `PCTD_ASSERT_ALWAYS(a_idle_in_reset, clk, !rst_n |=> !out_valid, "out_valid during reset")

    // a stalled item stays offered
    `PCTD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out_valid dropped while stalled")

    // a stalled item keeps its payload
    `PCTD_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_byte) && $stable(run_last) && $stable(string_end), "output item changed while stalled")

endmodule

bind percent_decoder_filtered pctd_checker u_pctd_checker (.*);
